@@ hw/rtl/top_k_score_tracker_macros.svh @@
// ---------------------------------------------------------------------------
// top_k_score_tracker_macros
// Assertion macros shared by the checker files of the top-K score tracker.
// ---------------------------------------------------------------------------
`ifndef TOP_K_SCORE_TRACKER_MACROS_SVH
`define TOP_K_SCORE_TRACKER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define TKST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define TKST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/tkst_pkg.sv @@
// ---------------------------------------------------------------------------
// tkst_pkg
// Types, constants and codes shared by the top-K score tracker modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tkst_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = 9;
  localparam int ID_W     = 31;
  localparam int SCORE_W  = 32;

  localparam logic [SCORE_W-1:0] MOST_NEG = {1'b1, {(SCORE_W-1){1'b0}}};

  // Operation codes.
  localparam logic [1:0] FN_OFFER  = 2'd0;
  localparam logic [1:0] FN_POP    = 2'd1;
  localparam logic [1:0] FN_DELETE = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_BELOW     = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_POPPED    = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;
  localparam logic [2:0] ST_DELETED   = 3'd5;
  localparam logic [2:0] ST_NOTFOUND  = 3'd6;

  typedef struct packed {
    logic [1:0]                func;
    logic [ID_W-1:0]           id;
    logic signed [SCORE_W-1:0] score;
  } in_item_t;

  typedef struct packed {
    logic [2:0]                status;
    logic [ID_W-1:0]           out_id;
    logic signed [SCORE_W-1:0] out_score;
    logic [CNT_W-1:0]          count;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;
    logic             step;
    logic             finish;
    logic [IDX_W-1:0] idx;
  } dp_cmd_t;

endpackage

@@ hw/rtl/top_k_score_tracker.sv @@
// ---------------------------------------------------------------------------
// top_k_score_tracker
// Holds the best (id, score) pairs of a stream and serves offer, pop, delete.
// ---------------------------------------------------------------------------
// Every command is first taken in with the transfer. Then the single compare
// unit walks the table slot by slot for the minimum, maximum or id match, and
// then the update is made. The result appears with out_valid high for exactly
// one cycle, in the first cycle that busy is low again, and must be captured
// then because the block cannot be stalled. A new start may be given in that
// same cycle.
`timescale 1ns / 1ps

module top_k_score_tracker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tkst_pkg::in_item_t  in_item,
  output logic                out_valid,
  output tkst_pkg::out_item_t out_item
);

  tkst_pkg::dp_cmd_t cmd;

  tkst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  tkst_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

@@ hw/rtl/tkst_ctrl.sv @@
// ---------------------------------------------------------------------------
// tkst_ctrl
// Sequencer: accepts a command, walks the slot index, then requests the update.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tkst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_valid,
  output tkst_pkg::dp_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam logic [tkst_pkg::IDX_W-1:0] LAST_IDX =
    tkst_pkg::IDX_W'(tkst_pkg::CAPACITY - 1);

  logic [1:0]                 state_r, state_nxt;
  logic [tkst_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                       out_valid_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SCAN;
          idx_nxt   = '0;
        end
      end
      S_SCAN: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= (state_r == S_DONE);
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign cmd.load   = start && (state_r == S_IDLE);
  assign cmd.step   = (state_r == S_SCAN);
  assign cmd.finish = (state_r == S_DONE);
  assign cmd.idx    = idx_r;

endmodule

@@ hw/rtl/tkst_dp.sv @@
// ---------------------------------------------------------------------------
// tkst_dp
// Slot table, one-slot-per-cycle scan unit and the update/result logic.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tkst_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  tkst_pkg::dp_cmd_t   cmd,
  input  tkst_pkg::in_item_t  in_item,
  output tkst_pkg::out_item_t out_item
);

  localparam int IW = tkst_pkg::IDX_W;
  localparam int CW = tkst_pkg::CNT_W;
  localparam int SW = tkst_pkg::SCORE_W;

  // Slot table.
  logic [tkst_pkg::CAPACITY-1:0] valid_r;
  logic [tkst_pkg::ID_W-1:0]     id_r    [tkst_pkg::CAPACITY];
  logic [SW-1:0]                 score_r [tkst_pkg::CAPACITY];

  logic [CW-1:0]      count_r, count_nxt;
  logic [IW-1:0]      target_r, target_nxt;
  logic [SW-1:0]      min_r, min_nxt;
  tkst_pkg::in_item_t req_r;

  // Scan accumulators.
  logic                      have_r, have_nxt;
  logic [IW-1:0]             best_idx_r, best_idx_nxt;
  logic [SW-1:0]             best_score_r, best_score_nxt;
  logic [tkst_pkg::ID_W-1:0] best_id_r, best_id_nxt;
  logic                      hit_r, hit_nxt;
  logic [IW-1:0]             hit_idx_r, hit_idx_nxt;
  logic                      free_r, free_nxt;
  logic [IW-1:0]             free_idx_r, free_idx_nxt;

  tkst_pkg::out_item_t out_r, out_nxt;

  logic                      cur_v, is_tgt, eff_v, id_eq;
  logic [tkst_pkg::ID_W-1:0] cur_id;
  logic [SW-1:0]             cur_s, eff_s;
  logic                      full;
  logic                      ins_en, clr_en;
  logic [IW-1:0]             clr_idx;

  assign cur_v  = valid_r[cmd.idx];
  assign cur_id = id_r[cmd.idx];
  assign cur_s  = score_r[cmd.idx];
  // During an offer the target slot is seen as already holding the new pair,
  // so the minimum for the next insertion falls out of the same pass.
  assign is_tgt = (cmd.idx == target_r);
  assign eff_v  = cur_v | is_tgt;
  assign eff_s  = is_tgt ? req_r.score : cur_s;
  assign id_eq  = cur_v && (cur_id == req_r.id);
  assign full   = (count_r >= CW'(tkst_pkg::CAPACITY));

  always_comb begin
    have_nxt       = have_r;
    best_idx_nxt   = best_idx_r;
    best_score_nxt = best_score_r;
    best_id_nxt    = best_id_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    if (cmd.load) begin
      have_nxt = 1'b0;
      hit_nxt  = 1'b0;
      free_nxt = 1'b0;
    end else if (cmd.step) begin
      unique case (req_r.func)
        tkst_pkg::FN_OFFER: begin
          if (id_eq) begin
            hit_nxt = 1'b1;
          end
          if (!eff_v && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = cmd.idx;
          end
          if (eff_v && (!have_r || ($signed(eff_s) < $signed(best_score_r)))) begin
            have_nxt       = 1'b1;
            best_idx_nxt   = cmd.idx;
            best_score_nxt = eff_s;
          end
        end
        tkst_pkg::FN_POP: begin
          if (cur_v && (!have_r || ($signed(cur_s) > $signed(best_score_r)))) begin
            have_nxt       = 1'b1;
            best_idx_nxt   = cmd.idx;
            best_score_nxt = cur_s;
            best_id_nxt    = cur_id;
          end
        end
        tkst_pkg::FN_DELETE: begin
          if (id_eq && !hit_r) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = cmd.idx;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    count_nxt         = count_r;
    target_nxt        = target_r;
    min_nxt           = min_r;
    ins_en            = 1'b0;
    clr_en            = 1'b0;
    clr_idx           = best_idx_r;
    out_nxt           = out_r;
    out_nxt.status    = tkst_pkg::ST_NOTFOUND;
    out_nxt.out_id    = '0;
    out_nxt.out_score = '0;
    if (cmd.finish) begin
      unique case (req_r.func)
        tkst_pkg::FN_OFFER: begin
          if (full && ($signed(req_r.score) <= $signed(min_r))) begin
            out_nxt.status = tkst_pkg::ST_BELOW;
          end else if (hit_r) begin
            out_nxt.status = tkst_pkg::ST_DUPLICATE;
          end else begin
            ins_en = 1'b1;
            if (!valid_r[target_r]) begin
              count_nxt = count_r + 1'b1;
            end
            target_nxt     = free_r ? free_idx_r : best_idx_r;
            min_nxt        = free_r ? tkst_pkg::MOST_NEG : best_score_r;
            out_nxt.status = tkst_pkg::ST_INSERTED;
          end
        end
        tkst_pkg::FN_POP: begin
          if (!have_r) begin
            out_nxt.status = tkst_pkg::ST_EMPTY;
          end else begin
            clr_en            = 1'b1;
            clr_idx           = best_idx_r;
            out_nxt.out_id    = best_id_r;
            out_nxt.out_score = best_score_r;
            out_nxt.status    = tkst_pkg::ST_POPPED;
          end
        end
        tkst_pkg::FN_DELETE: begin
          if (hit_r) begin
            clr_en         = 1'b1;
            clr_idx        = hit_idx_r;
            out_nxt.status = tkst_pkg::ST_DELETED;
          end
        end
        default: begin
        end
      endcase
      // A freed slot becomes the next insertion target.
      if (clr_en) begin
        target_nxt = clr_idx;
        min_nxt    = tkst_pkg::MOST_NEG;
        if (count_r != '0) begin
          count_nxt = count_r - 1'b1;
        end
      end
      out_nxt.count = count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      count_r  <= '0;
      target_r <= '0;
      min_r    <= tkst_pkg::MOST_NEG;
    end else begin
      count_r  <= count_nxt;
      target_r <= target_nxt;
      min_r    <= min_nxt;
      if (ins_en) begin
        valid_r[target_r] <= 1'b1;
      end
      if (clr_en) begin
        valid_r[clr_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_item;
    end
    if (ins_en) begin
      id_r[target_r]    <= req_r.id;
      score_r[target_r] <= req_r.score;
    end
    have_r       <= have_nxt;
    best_idx_r   <= best_idx_nxt;
    best_score_r <= best_score_nxt;
    best_id_r    <= best_id_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    free_r       <= free_nxt;
    free_idx_r   <= free_idx_nxt;
    out_r        <= out_nxt;
  end

  assign out_item = out_r;

endmodule

@@ hw/rtl/tkst_checker.sv @@
// ---------------------------------------------------------------------------
// tkst_checker
// Port-level checks of the top-K score tracker, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "top_k_score_tracker_macros.svh"

module tkst_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input tkst_pkg::out_item_t out_item
);

  logic count_ok;
  logic status_ok;
  logic payload_zero;
  logic popped;

  assign count_ok     = (out_item.count <= tkst_pkg::CNT_W'(tkst_pkg::CAPACITY));
  assign status_ok    = (out_item.status <= tkst_pkg::ST_NOTFOUND);
  assign payload_zero = (out_item.out_id == '0) && (out_item.out_score == '0);
  assign popped       = (out_item.status == tkst_pkg::ST_POPPED);

  `TKST_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transfer did not raise busy")
  `TKST_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe held longer than one cycle")
  `TKST_ASSERT_NOW(a_count_range, out_valid, count_ok, "count exceeds capacity")
  `TKST_ASSERT_NOW(a_status_code, out_valid, status_ok, "undefined status code")
  `TKST_ASSERT_NOW(a_zero_payload, out_valid && !popped, payload_zero, "payload not zero outside a pop")

endmodule

bind top_k_score_tracker tkst_checker u_tkst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

@@ tb/sv/tb_top_k_score_tracker.sv @@
// ---------------------------------------------------------------------------
// tb_top_k_score_tracker
// Self-checking bench for the top-K score tracker command interface.
// ---------------------------------------------------------------------------
// A shadow copy of the slot table predicts status, popped pair and count for
// every accepted command. Directed commands cover the empty table, the unused
// function code, score and id extremes, duplicates, a full table, and pop
// ties. Random traffic follows, with periodic drains to an empty table. Each
// result strobe is compared with the oldest prediction.
`timescale 1ns / 1ps

module tb_top_k_score_tracker;
  import tkst_pkg::*;

  localparam logic [1:0] FN_UNUSED   = 2'd3;
  localparam int         TAIL_CYCLES = 4 * (CAPACITY + 2);
  localparam int         DRAIN_LIMIT = 200000;
  localparam int         N_RANDOM    = 1850;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  top_k_score_tracker DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // Shadow copy of the slot table.
  logic                      held_valid [CAPACITY];
  logic [ID_W-1:0]           held_id    [CAPACITY];
  logic signed [SCORE_W-1:0] held_score [CAPACITY];
  logic [CNT_W-1:0]          held_count;
  int                        next_slot;
  logic signed [SCORE_W-1:0] floor_score;

  out_item_t pending_results[$];
  out_item_t oldest_result;
  int        mismatches = 0;
  bit        gaps_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void clear_table();
    for (int i = 0; i < CAPACITY; i++) begin
      held_valid[i] = 1'b0;
      held_id[i]    = '0;
      held_score[i] = '0;
    end
    held_count  = '0;
    next_slot   = 0;
    floor_score = MOST_NEG;
  endfunction

  // After an insert the target is the first free slot, or else the first
  // slot holding the smallest score.
  function automatic void rescan_floor();
    int lowest;
    lowest = -1;
    for (int i = 0; i < CAPACITY; i++) begin
      if (!held_valid[i]) begin
        next_slot   = i;
        floor_score = MOST_NEG;
        return;
      end
      if (lowest < 0 || held_score[i] < held_score[lowest]) lowest = i;
    end
    next_slot   = lowest;
    floor_score = held_score[lowest];
  endfunction

  function automatic void release_slot(int i);
    held_valid[i] = 1'b0;
    next_slot     = i;
    floor_score   = MOST_NEG;
    if (held_count > 0) held_count--;
  endfunction

  function automatic out_item_t apply_op(in_item_t it);
    out_item_t res;
    int        highest;
    logic      dup;
    res        = '0;
    res.status = ST_NOTFOUND;
    highest    = -1;
    dup        = 1'b0;
    case (it.func)
      FN_OFFER: begin
        if (held_count >= CAPACITY && $signed(it.score) <= floor_score) begin
          res.status = ST_BELOW;
        end else begin
          for (int i = 0; i < CAPACITY; i++)
            if (held_valid[i] && held_id[i] == it.id) dup = 1'b1;
          if (dup) begin
            res.status = ST_DUPLICATE;
          end else begin
            if (!held_valid[next_slot]) held_count++;
            held_valid[next_slot] = 1'b1;
            held_id[next_slot]    = it.id;
            held_score[next_slot] = it.score;
            res.status            = ST_INSERTED;
            rescan_floor();
          end
        end
      end
      FN_POP: begin
        for (int i = 0; i < CAPACITY; i++)
          if (held_valid[i] && (highest < 0 || held_score[i] > held_score[highest]))
            highest = i;
        if (highest < 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.out_id    = held_id[highest];
          res.out_score = held_score[highest];
          res.status    = ST_POPPED;
          release_slot(highest);
        end
      end
      FN_DELETE: begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (res.status == ST_NOTFOUND && held_valid[i] && held_id[i] == it.id) begin
            release_slot(i);
            res.status = ST_DELETED;
          end
        end
      end
      default: ;
    endcase
    res.count = held_count;
    return res;
  endfunction

  // Issues one command and records its predicted result once the transfer
  // has happened. start stays high when the next command follows at once.
  task automatic send_op(input logic [1:0] fn, input logic [ID_W-1:0] id_v,
                         input logic [SCORE_W-1:0] sc);
    in_item_t it;
    it.func  = fn;
    it.id    = id_v;
    it.score = sc;
    if (gaps_on && $urandom_range(0, 99) < 17) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 2 * CAPACITY)) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(apply_op(it));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result with nothing expected: status %0d id %0h score %0h count %0d",
                   $realtime, out_item.status, out_item.out_id, out_item.out_score,
                   out_item.count);
        mismatches++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_item.status    !== oldest_result.status ||
            out_item.out_id    !== oldest_result.out_id ||
            out_item.out_score !== oldest_result.out_score ||
            out_item.count     !== oldest_result.count) begin
          if (mismatches < 10)
            $display("%0t: mismatch: expected status %0d id %0h score %0h count %0d, got %s",
                     $realtime, oldest_result.status, oldest_result.out_id,
                     oldest_result.out_score, oldest_result.count,
                     $sformatf("status %0d id %0h score %0h count %0d", out_item.status,
                               out_item.out_id, out_item.out_score, out_item.count));
          mismatches++;
        end
      end
    end
  end

  task automatic test_empty_table();
    send_op(FN_POP, '0, '0);
    send_op(FN_DELETE, 31'h7FFF_FFFF, '0);
    send_op(FN_UNUSED, 31'h2AAA_AAAA, 32'h5555_5555);
  endtask

  // Fills the table with both score extremes, both id extremes, a tie at the
  // top score and a duplicate offer just before the last free slot is used.
  task automatic test_fill_extremes();
    send_op(FN_OFFER, '0, MOST_NEG);
    send_op(FN_OFFER, 31'h7FFF_FFFF, 32'h7FFF_FFFF);
    for (int i = 2; i < CAPACITY - 1; i++)
      send_op(FN_OFFER, 31'(100 + i),
              (i == 9) ? 32'h7FFF_FFFF : 32'((i - 8) * 65536));
    send_op(FN_OFFER, '0, 32'sd5);
    send_op(FN_OFFER, 31'd116, 32'h0001_8000);
  endtask

  task automatic test_full_table();
    // A held id with a score equal to the minimum is turned away as too low.
    send_op(FN_OFFER, 31'h7FFF_FFFF, MOST_NEG);
    send_op(FN_OFFER, 31'd200, MOST_NEG + 32'd1);
    send_op(FN_OFFER, 31'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_op(FN_POP, '0, '0);
    send_op(FN_OFFER, 31'd201, '0);
    send_op(FN_DELETE, 31'd109, '0);
  endtask

  task automatic drain_table();
    while (held_count > 0) send_op(FN_POP, ID_W'($urandom), $urandom);
    send_op(FN_POP, ID_W'($urandom), $urandom);
  endtask

  task automatic test_random_traffic(input int n_ops);
    int                  quiet_lo;
    int                  pick;
    int                  slot;
    logic [ID_W-1:0]     id_v;
    logic [SCORE_W-1:0]  sc;
    quiet_lo = n_ops / 3;
    for (int n = 0; n < n_ops; n++) begin
      gaps_on = !(n >= quiet_lo && n < quiet_lo + 300);
      if (n % 400 == 399) drain_table();
      // A small id pool keeps duplicates and successful deletes frequent.
      id_v = ($urandom_range(0, 9) < 7) ? 31'($urandom_range(0, 23)) : 31'($urandom);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: sc = $urandom;
        4, 5, 6:    sc = 32'($urandom_range(0, 15)) - 32'd8;
        7:          sc = $urandom_range(0, 1) ? MOST_NEG : ~MOST_NEG;
        default:    sc = floor_score + 32'($urandom_range(0, 2)) - 32'd1;
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_op(FN_OFFER, id_v, sc);
      end else if (pick < 75) begin
        send_op(FN_POP, id_v, sc);
      end else if (pick < 95) begin
        if (held_count > 0 && $urandom_range(0, 9) < 7) begin
          slot = $urandom_range(0, CAPACITY - 1);
          while (!held_valid[slot]) slot = (slot + 1) % CAPACITY;
          id_v = held_id[slot];
        end
        send_op(FN_DELETE, id_v, sc);
      end else begin
        send_op(FN_UNUSED, id_v, sc);
      end
    end
    drain_table();
  endtask

  initial begin
    start   <= 1'b0;
    in_item <= '0;
    rst_n   <= 1'b0;
    clear_table();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_fill_extremes();
    test_full_table();
    test_random_traffic(N_RANDOM);
    start <= 1'b0;

    for (int c = 0; c < DRAIN_LIMIT && pending_results.size() > 0; c++) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/tkst_pkg.sv
hw/rtl/tkst_ctrl.sv
hw/rtl/tkst_dp.sv
hw/rtl/top_k_score_tracker.sv
hw/rtl/tkst_checker.sv
tb/sv/tb_top_k_score_tracker.sv
